// ===== hw/rtl/vcs_pkg.sv =====
// ----------------------------------------------------------------------------
// vcs_pkg
// Shared types and codes for the valve cycle statistics block: payload words,
// op codes, statistic ids, register indexes and controller/datapath links.
// ----------------------------------------------------------------------------
package vcs_pkg;

  // field widths
  localparam int unsigned OP_W       = 3;
  localparam int unsigned TEMP_W     = 10;
  localparam int unsigned ID_W       = 4;
  localparam int unsigned STAT_W     = 32;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned PHASE_W    = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned NUM_STATS  = 11;

  // reset values
  localparam logic [TEMP_W-1:0]     TEMP_TOP      = 10'd1023;
  localparam logic [PHASE_W-1:0]    TICKS_SEC_RST = 16'd1000;
  localparam logic [PHASE_W-1:0]    TICKS_MIN_RST = 16'd60000;

  // input op codes
  localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
  localparam logic [OP_W-1:0] OP_TEMP  = 3'd1;
  localparam logic [OP_W-1:0] OP_OPEN  = 3'd2;
  localparam logic [OP_W-1:0] OP_CLOSE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

  // statistic ids, in emit order
  localparam logic [ID_W-1:0] STAT_CLEAR        = 4'd0;
  localparam logic [ID_W-1:0] STAT_TMIN         = 4'd1;
  localparam logic [ID_W-1:0] STAT_TMAX         = 4'd2;
  localparam logic [ID_W-1:0] STAT_LAST_CLOSED  = 4'd3;
  localparam logic [ID_W-1:0] STAT_LAST_OPEN    = 4'd4;
  localparam logic [ID_W-1:0] STAT_COUNT_OPEN   = 4'd5;
  localparam logic [ID_W-1:0] STAT_COUNT_CLOSED = 4'd6;
  localparam logic [ID_W-1:0] STAT_CURRENT      = 4'd7;
  localparam logic [ID_W-1:0] STAT_AVG_CLOSED   = 4'd8;
  localparam logic [ID_W-1:0] STAT_AVG_OPEN     = 4'd9;
  localparam logic [ID_W-1:0] STAT_UPTIME       = 4'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_SEC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_MIN = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TEMP_W-1:0] temperature;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0]   stat_id;
    logic [STAT_W-1:0] stat_value;
    logic              last;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic mul;
    logic div_init;
    logic div_step;
    logic avg_wr;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic avg_req;
    logic pend_any;
    logic pend_last;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/vcs_datapath.sv =====
// ----------------------------------------------------------------------------
// vcs_datapath
// Statistic registers, tick phases, running-average multiply and restoring
// divider, pending result mask and the output word register.
// ----------------------------------------------------------------------------
module vcs_datapath import vcs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  in_word_t              in_data_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output logic                  out_valid_o,
  output out_word_t             out_data_o,
  input  logic                  out_stall_i
);

  localparam int unsigned PROD_W = STAT_W + CNT_W;
  localparam int unsigned DVD_W  = PROD_W + 1;

  function automatic logic [CNT_W-1:0] sat16_inc(input logic [CNT_W-1:0] v);
    sat16_inc = (&v) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [STAT_W-1:0] sat32_inc(input logic [STAT_W-1:0] v);
    sat32_inc = (&v) ? v : v + STAT_W'(1);
  endfunction

  // configuration and statistics
  logic [PHASE_W-1:0] ticks_sec_q, ticks_min_q;
  logic [PHASE_W-1:0] sec_phase_q, min_phase_q;
  logic [TEMP_W-1:0]  temp_low_q, temp_high_q;
  logic [STAT_W-1:0]  last_closed_q, last_open_q;
  logic [STAT_W-1:0]  mean_closed_q, mean_open_q;
  logic [CNT_W-1:0]   opens_q, closes_q;
  logic [STAT_W-1:0]  cur_secs_q, uptime_q;

  // per-word working registers
  logic [OP_W-1:0]      op_q;
  logic [NUM_STATS-1:0] pend_q, pend_d;
  logic [PROD_W-1:0]    prod_q;
  logic [CNT_W-1:0]     rem_q, dvs_q;
  logic [STAT_W-1:0]    quo_q;
  logic                 out_valid_q;
  out_word_t            out_data_q;

  // tick phase arithmetic
  logic [PHASE_W-1:0] sec_inc, min_inc;
  logic               sec_done, min_done;

  assign sec_inc  = sec_phase_q + PHASE_W'(1);
  assign min_inc  = min_phase_q + PHASE_W'(1);
  assign sec_done = (sec_inc >= ticks_sec_q);
  assign min_done = (min_inc >= ticks_min_q);

  // operands of the running average for the state that just ended
  logic              end_open;
  logic [CNT_W-1:0]  cnt_sel, cnt_m1;
  logic [STAT_W-1:0] mean_sel, sample_sel;
  logic [PROD_W-1:0] mul_res;
  logic [DVD_W-1:0]  dividend;
  logic [CNT_W:0]    trial, trial_diff;
  logic              trial_ge;

  assign end_open   = (op_q == OP_OPEN);
  assign cnt_sel    = end_open ? closes_q : opens_q;
  assign mean_sel   = end_open ? mean_closed_q : mean_open_q;
  assign sample_sel = end_open ? last_closed_q : last_open_q;
  assign cnt_m1     = cnt_sel - CNT_W'(1);
  assign mul_res    = PROD_W'(mean_sel) * PROD_W'(cnt_m1);
  assign dividend   = {1'b0, prod_q} + DVD_W'(sample_sel);

  // one quotient bit per step
  assign trial      = {rem_q, quo_q[STAT_W-1]};
  assign trial_ge   = (trial >= {1'b0, dvs_q});
  assign trial_diff = trial - {1'b0, dvs_q};

  // mask of statistics that change with the incoming word
  logic [NUM_STATS-1:0] acc_mask;

  always_comb begin
    acc_mask = '0;
    case (in_data_i.op)
      OP_TICK: begin
        acc_mask[STAT_CURRENT] = sec_done;
        acc_mask[STAT_UPTIME]  = min_done;
      end
      OP_TEMP: begin
        acc_mask[STAT_TMIN] = (in_data_i.temperature < temp_low_q);
        acc_mask[STAT_TMAX] = (in_data_i.temperature > temp_high_q);
      end
      OP_OPEN: begin
        acc_mask[STAT_LAST_CLOSED] = 1'b1;
        acc_mask[STAT_COUNT_OPEN]  = 1'b1;
        acc_mask[STAT_CURRENT]     = 1'b1;
      end
      OP_CLOSE: begin
        acc_mask[STAT_LAST_OPEN]    = 1'b1;
        acc_mask[STAT_COUNT_CLOSED] = 1'b1;
        acc_mask[STAT_CURRENT]      = 1'b1;
      end
      OP_CLEAR: begin
        acc_mask[STAT_CLEAR] = 1'b1;
      end
      default: begin
        acc_mask = '0;
      end
    endcase
  end

  // lowest pending statistic goes out first
  logic [NUM_STATS-1:0] low_bit;
  logic [ID_W-1:0]      sel_id;
  logic                 sel_found;

  assign low_bit = pend_q & (~pend_q + NUM_STATS'(1));

  always_comb begin
    sel_id    = STAT_CLEAR;
    sel_found = 1'b0;
    for (int i = 0; i < NUM_STATS; i++) begin
      if (pend_q[i] && !sel_found) begin
        sel_id    = ID_W'(i);
        sel_found = 1'b1;
      end
    end
  end

  // value of the selected statistic
  logic [STAT_W-1:0] sel_value;

  always_comb begin
    case (sel_id)
      STAT_TMIN:         sel_value = STAT_W'(temp_low_q);
      STAT_TMAX:         sel_value = STAT_W'(temp_high_q);
      STAT_LAST_CLOSED:  sel_value = last_closed_q;
      STAT_LAST_OPEN:    sel_value = last_open_q;
      STAT_COUNT_OPEN:   sel_value = STAT_W'(opens_q);
      STAT_COUNT_CLOSED: sel_value = STAT_W'(closes_q);
      STAT_CURRENT:      sel_value = cur_secs_q;
      STAT_AVG_CLOSED:   sel_value = mean_closed_q;
      STAT_AVG_OPEN:     sel_value = mean_open_q;
      STAT_UPTIME:       sel_value = uptime_q;
      default:           sel_value = '0;
    endcase
  end

  // pending mask next value
  always_comb begin
    pend_d = pend_q;
    if (cmd_i.accept) begin
      pend_d = acc_mask;
    end else if (cmd_i.avg_wr) begin
      if (end_open) begin
        pend_d[STAT_AVG_CLOSED] = 1'b1;
      end else begin
        pend_d[STAT_AVG_OPEN] = 1'b1;
      end
    end else if (cmd_i.emit) begin
      pend_d = pend_q & ~low_bit;
    end
  end

  // statistics, configuration and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_sec_q   <= TICKS_SEC_RST;
      ticks_min_q   <= TICKS_MIN_RST;
      sec_phase_q   <= '0;
      min_phase_q   <= '0;
      temp_low_q    <= TEMP_TOP;
      temp_high_q   <= '0;
      last_closed_q <= '0;
      last_open_q   <= '0;
      mean_closed_q <= '0;
      mean_open_q   <= '0;
      opens_q       <= '0;
      closes_q      <= '0;
      cur_secs_q    <= '0;
      uptime_q      <= '0;
      pend_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      pend_q <= pend_d;

      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TICKS_SEC: ticks_sec_q <= cfg_wdata_i;
          REG_TICKS_MIN: ticks_min_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end

      // state update for an accepted word
      if (cmd_i.accept) begin
        case (in_data_i.op)
          OP_TICK: begin
            if (sec_done) begin
              sec_phase_q <= '0;
              cur_secs_q  <= sat32_inc(cur_secs_q);
            end else begin
              sec_phase_q <= sec_inc;
            end
            if (min_done) begin
              min_phase_q <= '0;
              uptime_q    <= sat32_inc(uptime_q);
            end else begin
              min_phase_q <= min_inc;
            end
          end
          OP_TEMP: begin
            if (in_data_i.temperature < temp_low_q) begin
              temp_low_q <= in_data_i.temperature;
            end
            if (in_data_i.temperature > temp_high_q) begin
              temp_high_q <= in_data_i.temperature;
            end
          end
          OP_OPEN: begin
            last_closed_q <= cur_secs_q;
            opens_q       <= sat16_inc(opens_q);
            cur_secs_q    <= '0;
            sec_phase_q   <= '0;
            if (closes_q == '0) begin
              mean_closed_q <= '0;
            end
          end
          OP_CLOSE: begin
            last_open_q <= cur_secs_q;
            closes_q    <= sat16_inc(closes_q);
            cur_secs_q  <= '0;
            sec_phase_q <= '0;
            if (opens_q == '0) begin
              mean_open_q <= '0;
            end
          end
          OP_CLEAR: begin
            temp_low_q    <= TEMP_TOP;
            temp_high_q   <= '0;
            last_closed_q <= '0;
            last_open_q   <= '0;
            mean_closed_q <= '0;
            mean_open_q   <= '0;
            opens_q       <= '0;
            closes_q      <= '0;
            sec_phase_q   <= '0;
            min_phase_q   <= '0;
          end
          default: begin
          end
        endcase
      end

      // new running average
      if (cmd_i.avg_wr) begin
        if (end_open) begin
          mean_closed_q <= quo_q;
        end else begin
          mean_open_q <= quo_q;
        end
      end

      // output word valid
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and divider registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q <= in_data_i.op;
    end
    if (cmd_i.mul) begin
      prod_q <= mul_res;
    end
    // quotient fits in 32 bits, so the top dividend bits start as remainder
    if (cmd_i.div_init) begin
      rem_q <= dividend[PROD_W-1:STAT_W];
      quo_q <= dividend[STAT_W-1:0];
      dvs_q <= cnt_sel;
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_q <= {quo_q[STAT_W-2:0], trial_ge};
    end
    if (cmd_i.emit) begin
      out_data_q.stat_id    <= sel_id;
      out_data_q.stat_value <= sel_value;
      out_data_q.last       <= (pend_q == low_bit);
    end
  end

  // status back to the controller
  assign sts_o.avg_req   = ((in_data_i.op == OP_OPEN) && (closes_q != '0)) ||
                           ((in_data_i.op == OP_CLOSE) && (opens_q != '0));
  assign sts_o.pend_any  = |pend_q;
  assign sts_o.pend_last = (|pend_q) && (pend_q == low_bit);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/vcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// vcs_ctrl
// Controller: takes one word at a time, runs the multiply and divide steps of
// the running average when needed, then sends out the pending results.
// ----------------------------------------------------------------------------
module vcs_ctrl import vcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam int unsigned CNT_BITS = $clog2(STAT_W);
  localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(STAT_W - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIVI = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_AVG  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.avg_req ? S_MUL : S_EMIT;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIVI;
      end
      S_DIVI: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_BITS'(1);
        if (cnt_q == DIV_LAST) begin
          state_d = S_AVG;
        end
      end
      S_AVG: begin
        cmd_o.avg_wr = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (!sts_i.pend_any) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.pend_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ===== hw/rtl/valve_cycle_stats.sv =====
// Ticks, samples and clear go from accept straight to sending their results, if any.
// Valve events with a running average first pass the multiply, divider init, 32-step divider and average write states.
// A new input word is taken only once the block is idle again after the last word's results.
// Results leave one per cycle through the output register when not stalled.
// Reset (async, active low) restores configuration, statistics and control registers to reset values.
// ----------------------------------------------------------------------------
// valve_cycle_stats
// Statistics keeper for a valve controller: tick phases, temperature extremes,
// valve open and closed durations, counts and running averages.
// ----------------------------------------------------------------------------
module valve_cycle_stats import vcs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_data_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  vcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // statistics and arithmetic
  vcs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

`ifndef SYNTHESIS
  // an accepted word always keeps the block busy for the next cycle
  ap_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block idle right after accepting a word");

  // results never stay pending while the block takes new words
  ap_pend_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.pend_any |-> in_stall_o)
    else $error("pending results while idle");

  // the final result of a word returns the block to idle
  ap_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && sts.pend_last) |=> (!in_stall_o && out_valid_o && out_data_o.last))
    else $error("final result did not end the word");
`endif

endmodule
